/* sv/gtht_pkg.sv */
// Shared types and constants for the generation-tagged handle table.
// Used by gtht_ctrl, gtht_dp and generation_tagged_handle_table_core.
package gtht_pkg;

   localparam int unsigned SLOTS_DEFAULT = 16;
   localparam int unsigned MAX_RESULTS   = 16;
   localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] REQ_INSTALL      = 3'd0;
   localparam logic [2:0] REQ_LOOKUP_CHK   = 3'd1;
   localparam logic [2:0] REQ_LOOKUP_UNCHK = 3'd2;
   localparam logic [2:0] REQ_CLOSE        = 3'd3;
   localparam logic [2:0] REQ_CLOSE_ALL    = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INACTIVE  = 3'd1;
   localparam logic [2:0] ST_MALFORMED = 3'd2;
   localparam logic [2:0] ST_STALE     = 3'd3;
   localparam logic [2:0] ST_MISMATCH  = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_BADARG    = 3'd6;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] handle;
      logic [15:0] object_id;
      logic [3:0]  object_type;
      logic [7:0]  rights;
      logic [1:0]  need_rights;
      logic        object_live;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] handle_out;
      logic [15:0] found_object;
      logic        release_res;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic        active;
      logic [15:0] gen;
      logic [15:0] obj;
      logic [3:0]  typ;
      logic [1:0]  rights;
   } slot_entry_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept_ready;
      logic eval_en;
      logic flush_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
      logic eval_done;
      logic eval_flush;
   } dp_stat_type;

   // generation after install: wraps past 0xffff to 1, never 0
   function automatic logic [15:0] next_gen(input logic [15:0] g);
      logic [15:0] n;
      n = g + 16'd1;
      if (n == 16'd0) begin
         n = 16'd1;
      end
      return n;
   endfunction

endpackage

/* sv/generation_tagged_handle_table_core.sv */
// Generation-tagged capability handle table: top level joining gtht_ctrl and gtht_dp.
// Depends on gtht_pkg for the word types and table constants.
//
// After reset the table runs a clearing pass over every slot with
// req_stall high. Lookups, closes and unknown requests are accepted, the slot
// is read from the slot memory, then the result is formed. Install scans the
// slot memory one entry per cycle from slot 0 up to the first free slot, or
// through the last slot when the table is full. Close-all walks every slot,
// one per cycle, ending sooner once MAX_RESULTS slots were released. A word
// that waits in the output register with rsp_stall high halts the work, so
// the scans above keep that rate only while the output is not stalled.
// One request is worked on at a time; the next is taken while the last result
// word still waits in the output register.
module generation_tagged_handle_table_core #(
   parameter int unsigned SLOTS = gtht_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic                   csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gtht_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gtht_pkg::rsp_word_type rsp_word
);

   gtht_pkg::ctrl_cmd_type cmd;
   gtht_pkg::dp_stat_type  stat;
   logic                   req_accept;

   assign req_stall  = !cmd.accept_ready;
   assign req_accept = req_valid && cmd.accept_ready;

   gtht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   gtht_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_accept     (req_accept),
      .req_word       (req_word),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_word       (rsp_word),
      .cmd            (cmd),
      .stat           (stat)
   );

   a_clear_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> req_stall)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("second request taken while one is in work");

   a_partial_is_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last) |->
         (rsp_word.release_res && rsp_word.status == gtht_pkg::ST_OK))
      else $error("non-final word that is not a close-all release");

   a_handle_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.handle_out != 32'd0) |->
         (rsp_word.handle_out[31:16] != 16'd0 && rsp_word.handle_out[15:0] != 16'd0 &&
          rsp_word.status == gtht_pkg::ST_OK))
      else $error("issued handle with zero generation or index");

endmodule

/* sv/gtht_ctrl.sv */
// Sequencer for the handle table: clearing pass, idle, slot evaluation, flush.
// Depends on gtht_pkg; drives commands into gtht_dp and reads its status.
module gtht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  gtht_pkg::dp_stat_type stat,
   output gtht_pkg::ctrl_cmd_type cmd
);

   gtht_pkg::state_type state_ff;
   gtht_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtht_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         gtht_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = gtht_pkg::S_IDLE;
            end
         end
         gtht_pkg::S_IDLE: begin
            cmd.accept_ready = 1'b1;
            if (req_valid) begin
               state_in = gtht_pkg::S_EVAL;
            end
         end
         gtht_pkg::S_EVAL: begin
            if (stat.out_free) begin
               cmd.eval_en = 1'b1;
               priority if (stat.eval_done) begin
                  state_in = gtht_pkg::S_IDLE;
               end else if (stat.eval_flush) begin
                  state_in = gtht_pkg::S_FLUSH;
               end else begin
                  state_in = gtht_pkg::S_EVAL;
               end
            end
         end
         gtht_pkg::S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush_en = 1'b1;
               state_in     = gtht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gtht_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

/* sv/gtht_dp.sv */
// Datapath of the handle table: slot memory, request and address registers,
// handle checks, close-all pending word and the result register. Uses gtht_pkg.
module gtht_dp #(
   parameter int unsigned SLOTS = gtht_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic                   csr_write_data,
   input  logic                   req_accept,
   input  gtht_pkg::req_word_type req_word,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output gtht_pkg::rsp_word_type rsp_word,
   input  gtht_pkg::ctrl_cmd_type cmd,
   output gtht_pkg::dp_stat_type  stat
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   gtht_pkg::slot_entry_type slot_ff [SLOTS];
   gtht_pkg::slot_entry_type rd_ff;
   gtht_pkg::req_word_type   req_ff;
   gtht_pkg::rsp_word_type   rsp_ff;
   gtht_pkg::rsp_word_type   rsp_in;
   gtht_pkg::rsp_word_type   ev_res;
   gtht_pkg::rsp_word_type   flush_res;
   gtht_pkg::slot_entry_type ev_wdata;
   gtht_pkg::slot_entry_type mem_wdata;

   logic [IDX_W-1:0] addr_ff;
   logic [IDX_W-1:0] addr_in;
   logic [IDX_W-1:0] acc_idx;
   logic             owner_ff;
   logic             rsp_valid_ff;
   logic             pend_valid_ff;
   logic [15:0]      pend_obj_ff;
   logic [gtht_pkg::CNT_W-1:0] cnt_ff;
   logic [gtht_pkg::CNT_W-1:0] cnt_next;

   logic        acc_in_range;
   logic        ev_in_range;
   logic        ev_malformed;
   logic [2:0]  ev_resolve;
   logic [15:0] ev_gen;
   logic        at_last;
   logic        ev_emit;
   logic        ev_wr;
   logic        ev_done;
   logic        ev_flush;
   logic        ev_adv;
   logic        mem_we;
   logic        emit_fire;
   logic        out_free;
   logic        take_pend;

   // slot index from the handle presented at accept
   assign acc_in_range = (req_word.handle[15:0] != 16'd0) &&
                         (32'(req_word.handle[15:0]) <= 32'(SLOTS));
   assign acc_idx = acc_in_range ? IDX_W'(req_word.handle[15:0] - 16'd1) : '0;

   // handle checks on the registered request
   assign ev_in_range  = 32'(req_ff.handle[15:0]) <= 32'(SLOTS);
   assign ev_malformed = (req_ff.handle[15:0] == 16'd0) ||
                         (req_ff.handle[31:16] == 16'd0) || !ev_in_range;
   assign ev_gen       = gtht_pkg::next_gen(rd_ff.gen);
   assign at_last      = addr_ff == LAST_IDX;
   assign cnt_next     = cnt_ff + gtht_pkg::CNT_W'(1);

   always_comb begin
      priority if (ev_malformed) begin
         ev_resolve = gtht_pkg::ST_MALFORMED;
      end else if (!rd_ff.active || rd_ff.gen != req_ff.handle[31:16]) begin
         ev_resolve = gtht_pkg::ST_STALE;
      end else begin
         ev_resolve = gtht_pkg::ST_OK;
      end
   end

   always_comb begin
      ev_emit   = 1'b0;
      ev_wr     = 1'b0;
      ev_done   = 1'b0;
      ev_flush  = 1'b0;
      ev_adv    = 1'b0;
      take_pend = 1'b0;
      ev_wdata  = rd_ff;
      ev_res    = '0;
      ev_res.last = 1'b1;
      unique case (req_ff.req_type)
         gtht_pkg::REQ_INSTALL: begin
            priority if (!owner_ff) begin
               ev_emit       = 1'b1;
               ev_done       = 1'b1;
               ev_res.status = gtht_pkg::ST_INACTIVE;
            end else if (req_ff.rights[7:2] != 6'd0 || !req_ff.object_live) begin
               ev_emit       = 1'b1;
               ev_done       = 1'b1;
               ev_res.status = gtht_pkg::ST_BADARG;
            end else if (!rd_ff.active) begin
               ev_emit         = 1'b1;
               ev_done         = 1'b1;
               ev_wr           = 1'b1;
               ev_wdata.active = 1'b1;
               ev_wdata.gen    = ev_gen;
               ev_wdata.obj    = req_ff.object_id;
               ev_wdata.typ    = req_ff.object_type;
               ev_wdata.rights = req_ff.rights[1:0];
               ev_res.status   = gtht_pkg::ST_OK;
               ev_res.handle_out = {ev_gen, 16'(addr_ff) + 16'd1};
            end else if (at_last) begin
               ev_emit       = 1'b1;
               ev_done       = 1'b1;
               ev_res.status = gtht_pkg::ST_FULL;
            end else begin
               ev_adv = 1'b1;
            end
         end
         gtht_pkg::REQ_LOOKUP_CHK, gtht_pkg::REQ_LOOKUP_UNCHK: begin
            ev_emit = 1'b1;
            ev_done = 1'b1;
            priority if (req_ff.req_type == gtht_pkg::REQ_LOOKUP_CHK && !owner_ff) begin
               ev_res.status = gtht_pkg::ST_INACTIVE;
            end else if (ev_resolve != gtht_pkg::ST_OK) begin
               ev_res.status = ev_resolve;
            end else if ((req_ff.object_type != 4'd0 && rd_ff.typ != req_ff.object_type) ||
                         ((rd_ff.rights & req_ff.need_rights) !=
                          req_ff.need_rights)) begin
               ev_res.status = gtht_pkg::ST_MISMATCH;
            end else begin
               ev_res.status       = gtht_pkg::ST_OK;
               ev_res.found_object = rd_ff.obj;
            end
         end
         gtht_pkg::REQ_CLOSE: begin
            ev_emit       = 1'b1;
            ev_done       = 1'b1;
            ev_res.status = ev_resolve;
            if (ev_resolve == gtht_pkg::ST_OK) begin
               ev_wr               = 1'b1;
               ev_wdata.active     = 1'b0;
               ev_wdata.rights     = 2'd0;
               ev_res.found_object = rd_ff.obj;
               ev_res.release_res  = 1'b1;
            end
         end
         gtht_pkg::REQ_CLOSE_ALL: begin
            if (rd_ff.active) begin
               ev_wr           = 1'b1;
               ev_wdata.active = 1'b0;
               ev_wdata.rights = 2'd0;
               take_pend       = 1'b1;
               // the previous find is known not to be final now
               ev_emit             = pend_valid_ff;
               ev_res.status       = gtht_pkg::ST_OK;
               ev_res.found_object = pend_obj_ff;
               ev_res.release_res  = 1'b1;
               ev_res.last         = 1'b0;
               if (cnt_next == gtht_pkg::CNT_W'(gtht_pkg::MAX_RESULTS) || at_last) begin
                  ev_flush = 1'b1;
               end else begin
                  ev_adv = 1'b1;
               end
            end else if (at_last) begin
               ev_flush = 1'b1;
            end else begin
               ev_adv = 1'b1;
            end
         end
         default: begin
            ev_emit       = 1'b1;
            ev_done       = 1'b1;
            ev_res.status = gtht_pkg::ST_BADARG;
         end
      endcase
   end

   always_comb begin
      flush_res              = '0;
      flush_res.status       = gtht_pkg::ST_OK;
      flush_res.found_object = pend_valid_ff ? pend_obj_ff : 16'd0;
      flush_res.release_res  = pend_valid_ff;
      flush_res.last         = 1'b1;
   end

   always_comb begin
      addr_in = addr_ff;
      priority if (req_accept) begin
         if (req_word.req_type == gtht_pkg::REQ_LOOKUP_CHK ||
             req_word.req_type == gtht_pkg::REQ_LOOKUP_UNCHK ||
             req_word.req_type == gtht_pkg::REQ_CLOSE) begin
            addr_in = acc_idx;
         end else begin
            addr_in = '0;
         end
      end else if (cmd.clear_step && !at_last) begin
         addr_in = addr_ff + IDX_W'(1);
      end else if (cmd.eval_en && ev_adv) begin
         addr_in = addr_ff + IDX_W'(1);
      end else begin
         addr_in = addr_ff;
      end
   end

   assign mem_we    = cmd.clear_step || (cmd.eval_en && ev_wr);
   assign mem_wdata = cmd.clear_step ? '0 : ev_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_ff[addr_ff] <= mem_wdata;
      end
      rd_ff <= slot_ff[addr_in];
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = (cmd.eval_en && ev_emit) || cmd.flush_en;
   assign rsp_in    = cmd.flush_en ? flush_res : ev_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         owner_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         addr_ff <= addr_in;
         if (csr_write_en) begin
            owner_ff <= csr_write_data;
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_accept) begin
            pend_valid_ff <= 1'b0;
            cnt_ff        <= '0;
         end else if (cmd.eval_en && take_pend) begin
            pend_valid_ff <= 1'b1;
            cnt_ff        <= cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_word;
      end
      if (cmd.eval_en && take_pend) begin
         pend_obj_ff <= rd_ff.obj;
      end
      if (emit_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign stat.clear_done = at_last;
   assign stat.out_free   = out_free;
   assign stat.eval_done  = ev_done;
   assign stat.eval_flush = ev_flush;

endmodule
